// ===== sv/awst_pkg.sv =====
// shared constants, configuration and job types for the acoustic wave stencil
// no dependencies

package awst_pkg;

    localparam int RADIUS    = 4;
    localparam int MAX_NX    = 256;
    localparam int MAX_NY    = 256;
    localparam int MAX_NZ    = 1024;
    localparam int MIN_N     = 2 * RADIUS + 1;
    localparam int WIN_DEPTH = 2 * RADIUS * MAX_NX * MAX_NY + 2 * RADIUS * MAX_NX
                               + 2 * RADIUS + 1;
    localparam int DLY_DEPTH = RADIUS * MAX_NX * MAX_NY + RADIUS * MAX_NX + RADIUS;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int DLY_AW    = $clog2(DLY_DEPTH);
    localparam int PEND_W    = $clog2(DLY_DEPTH + 1);
    localparam int NXY_W     = $clog2(MAX_NX * MAX_NY + 1);
    localparam int R_W       = $clog2(RADIUS + 1);
    localparam int RING_N    = 4;
    localparam int RING_W    = $clog2(RING_N);
    localparam int XS_W      = 9;
    localparam int YS_W      = 9;
    localparam int ZS_W      = 11;
    localparam int DATA_W    = 32;
    localparam int VEL_W     = 24;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        CFG_COEFF_CENTER = 3'd0,
        CFG_COEFF_1      = 3'd1,
        CFG_COEFF_2      = 3'd2,
        CFG_COEFF_3      = 3'd3,
        CFG_COEFF_4      = 3'd4,
        CFG_GRID_X       = 3'd5,
        CFG_GRID_Y       = 3'd6,
        CFG_GRID_Z       = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0]             coeff_center;
        logic [RING_N-1:0][DATA_W-1:0] coeff_ring;
        logic [XS_W-1:0]               grid_x;
        logic [YS_W-1:0]               grid_y;
        logic [ZS_W-1:0]               grid_z;
    } cfg_t;

    typedef struct packed {
        logic              bnd;
        logic              last;
        logic [DATA_W-1:0] nxt;
        logic [VEL_W-1:0]  vel;
        logic [WIN_AW-1:0] slot;
        logic [XS_W-1:0]   nx;
        logic [NXY_W-1:0]  nxny;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [WIN_AW-1:0] addr;
        logic [DATA_W-1:0] data;
    } win_wr_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SIZE,
        F_PLAN,
        F_COMMIT
    } front_state_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_TAP,
        B_FLUSH,
        B_MLO,
        B_MHI,
        B_SUM,
        B_SAT,
        B_OUT
    } back_state_t;

endpackage

// ===== sv/awst_queue.sv =====
// small job queue between the front and back parts
// depends on awst_pkg

module awst_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  awst_pkg::job_t  din,
    input  logic            pop,
    output awst_pkg::job_t  dout,
    output logic            full,
    output logic            empty
);

    localparam int QA_W = $clog2(awst_pkg::QUEUE_DEPTH);

    awst_pkg::job_t  mem_reg [awst_pkg::QUEUE_DEPTH];
    logic [QA_W-1:0] wr_ptr_reg;
    logic [QA_W-1:0] rd_ptr_reg;
    logic [QA_W:0]   count_reg;

    assign full  = (count_reg == (QA_W + 1)'(awst_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== sv/awst_front.sv =====
// front part: accepts items, tracks raster positions, keeps the next/velocity delay
// memory and decides which point is emitted; depends on awst_pkg

module awst_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  awst_pkg::cfg_t         cfg,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [31:0]            in_prev,
    input  logic [31:0]            in_next,
    input  logic [23:0]            in_vel,
    input  logic                   in_drain,
    input  logic                   clear_done,
    input  logic                   q_full,
    output logic                   q_push,
    output awst_pkg::job_t         q_job,
    output awst_pkg::win_wr_t      win_wr
);

    localparam int XS_W   = awst_pkg::XS_W;
    localparam int YS_W   = awst_pkg::YS_W;
    localparam int ZS_W   = awst_pkg::ZS_W;
    localparam int WIN_AW = awst_pkg::WIN_AW;
    localparam int DLY_AW = awst_pkg::DLY_AW;
    localparam int PEND_W = awst_pkg::PEND_W;
    localparam int NXY_W  = awst_pkg::NXY_W;
    localparam int DLY_W  = awst_pkg::VEL_W + awst_pkg::DATA_W;

    typedef struct packed {
        logic [ZS_W-1:0] z;
        logic [YS_W-1:0] y;
        logic [XS_W-1:0] x;
    } pos_t;

    function automatic logic [ZS_W-1:0] clamp_size(input logic [ZS_W-1:0] v,
                                                   input logic [ZS_W-1:0] hi);
        logic [ZS_W-1:0] lo;
        lo = ZS_W'(awst_pkg::MIN_N);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic pos_t advance(input pos_t p, input logic [XS_W-1:0] nx,
                                     input logic [YS_W-1:0] ny, input logic [ZS_W-1:0] nz);
        pos_t n;
        n = p;
        if ({1'b0, p.x} + (XS_W + 1)'(1) >= {1'b0, nx}) begin
            n.x = '0;
            if ({1'b0, p.y} + (YS_W + 1)'(1) >= {1'b0, ny}) begin
                n.y = '0;
                if ({1'b0, p.z} + (ZS_W + 1)'(1) >= {1'b0, nz}) begin
                    n.z = '0;
                end else begin
                    n.z = p.z + 1'b1;
                end
            end else begin
                n.y = p.y + 1'b1;
            end
        end else begin
            n.x = p.x + 1'b1;
        end
        return n;
    endfunction

    awst_pkg::front_state_t state_reg, state_next;

    logic [31:0]       prev_reg;
    logic [31:0]       next_reg;
    logic [23:0]       vel_reg;
    logic              drain_reg;
    logic [XS_W-1:0]   nx_reg;
    logic [YS_W-1:0]   ny_reg;
    logic [ZS_W-1:0]   nz_reg;
    logic [NXY_W-1:0]  nxny_reg;
    pos_t              in_pos_reg;
    pos_t              out_pos_reg;
    logic [PEND_W-1:0] pending_reg;
    logic [WIN_AW-1:0] win_slot_reg;
    logic [DLY_AW-1:0] dly_slot_reg;
    logic [WIN_AW-1:0] job_slot_reg;
    logic              emit_reg;
    logic              bnd_reg;
    logic              last_reg;
    logic [WIN_AW-1:0] ws_reg;
    logic [DLY_AW-1:0] ds_reg;
    logic [DLY_W-1:0]  dly_q_reg;
    logic [DLY_W-1:0]  dly_mem [awst_pkg::DLY_DEPTH];

    logic [XS_W-1:0]     nx_c;
    logic [YS_W-1:0]     ny_c;
    logic [ZS_W-1:0]     nz_c;
    logic [2*XS_W-1:0]   nxny_prod;
    logic [PEND_W-1:0]   lag_c;
    logic                at_origin;
    logic                emit_c;
    logic                bnd_c;
    logic                last_c;
    logic [PEND_W-1:0]   pend_dec;
    logic [WIN_AW-1:0]   win_inc;
    logic [DLY_AW-1:0]   dly_inc;
    logic [WIN_AW-1:0]   win_new;
    logic [DLY_AW-1:0]   dly_new;
    logic [WIN_AW:0]     ws_sum;
    logic [DLY_AW:0]     ds_sum;
    logic                accept;

    assign accept = s_valid && s_ready;

    always_comb begin
        nx_c      = XS_W'(clamp_size(ZS_W'(cfg.grid_x), ZS_W'(awst_pkg::MAX_NX)));
        ny_c      = YS_W'(clamp_size(ZS_W'(cfg.grid_y), ZS_W'(awst_pkg::MAX_NY)));
        nz_c      = clamp_size(cfg.grid_z, ZS_W'(awst_pkg::MAX_NZ));
        nxny_prod = (2 * XS_W)'(nx_c) * (2 * XS_W)'(ny_c);

        lag_c     = PEND_W'(awst_pkg::RADIUS)
                    * (PEND_W'(nxny_reg) + PEND_W'(nx_reg) + PEND_W'(1));
        at_origin = (in_pos_reg == '0);
        emit_c    = drain_reg ? (at_origin && pending_reg != '0) : (pending_reg >= lag_c);
        bnd_c     = out_pos_reg.x < XS_W'(awst_pkg::RADIUS)
                 || out_pos_reg.y < YS_W'(awst_pkg::RADIUS)
                 || out_pos_reg.z < ZS_W'(awst_pkg::RADIUS)
                 || out_pos_reg.x >= nx_reg - XS_W'(awst_pkg::RADIUS)
                 || out_pos_reg.y >= ny_reg - YS_W'(awst_pkg::RADIUS)
                 || out_pos_reg.z >= nz_reg - ZS_W'(awst_pkg::RADIUS);
        last_c    = out_pos_reg.x == nx_reg - 1'b1
                 && out_pos_reg.y == ny_reg - 1'b1
                 && out_pos_reg.z == nz_reg - 1'b1;

        win_inc  = (win_slot_reg == WIN_AW'(awst_pkg::WIN_DEPTH - 1))
                   ? '0 : win_slot_reg + 1'b1;
        dly_inc  = (dly_slot_reg == DLY_AW'(awst_pkg::DLY_DEPTH - 1))
                   ? '0 : dly_slot_reg + 1'b1;
        pend_dec = emit_c ? pending_reg - 1'b1 : pending_reg;
        win_new  = emit_c ? win_inc : win_slot_reg;
        dly_new  = emit_c ? dly_inc : dly_slot_reg;

        ws_sum = {1'b0, win_new} + (WIN_AW + 1)'(pend_dec);
        if (ws_sum >= (WIN_AW + 1)'(awst_pkg::WIN_DEPTH)) begin
            ws_sum = ws_sum - (WIN_AW + 1)'(awst_pkg::WIN_DEPTH);
        end
        ds_sum = {1'b0, dly_new} + (DLY_AW + 1)'(pend_dec);
        if (ds_sum >= (DLY_AW + 1)'(awst_pkg::DLY_DEPTH)) begin
            ds_sum = ds_sum - (DLY_AW + 1)'(awst_pkg::DLY_DEPTH);
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        q_push     = 1'b0;
        unique case (state_reg)
            awst_pkg::F_IDLE: begin
                s_ready = clear_done && !q_full;
                if (s_valid && s_ready) begin
                    state_next = awst_pkg::F_SIZE;
                end
            end
            awst_pkg::F_SIZE: begin
                state_next = awst_pkg::F_PLAN;
            end
            awst_pkg::F_PLAN: begin
                state_next = awst_pkg::F_COMMIT;
            end
            awst_pkg::F_COMMIT: begin
                q_push     = emit_reg;
                state_next = awst_pkg::F_IDLE;
            end
            default: begin
                state_next = awst_pkg::F_IDLE;
            end
        endcase
    end

    always_comb begin
        q_job.bnd  = bnd_reg;
        q_job.last = last_reg;
        q_job.nxt  = dly_q_reg[awst_pkg::DATA_W-1:0];
        q_job.vel  = dly_q_reg[DLY_W-1:awst_pkg::DATA_W];
        q_job.slot = job_slot_reg;
        q_job.nx   = nx_reg;
        q_job.nxny = nxny_reg;

        win_wr.en   = (state_reg == awst_pkg::F_COMMIT) && !drain_reg;
        win_wr.addr = ws_reg;
        win_wr.data = prev_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= awst_pkg::F_IDLE;
            in_pos_reg   <= '0;
            out_pos_reg  <= '0;
            pending_reg  <= '0;
            win_slot_reg <= '0;
            dly_slot_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == awst_pkg::F_PLAN) begin
                pending_reg  <= drain_reg ? pend_dec : pend_dec + PEND_W'(1);
                win_slot_reg <= win_new;
                dly_slot_reg <= dly_new;
                if (emit_c) begin
                    out_pos_reg <= advance(out_pos_reg, nx_reg, ny_reg, nz_reg);
                end
                if (!drain_reg) begin
                    in_pos_reg <= advance(in_pos_reg, nx_reg, ny_reg, nz_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_reg  <= in_prev;
            next_reg  <= in_next;
            vel_reg   <= in_vel;
            drain_reg <= in_drain;
        end
        if (state_reg == awst_pkg::F_SIZE) begin
            nx_reg   <= nx_c;
            ny_reg   <= ny_c;
            nz_reg   <= nz_c;
            nxny_reg <= NXY_W'(nxny_prod);
        end
        if (state_reg == awst_pkg::F_PLAN) begin
            emit_reg     <= emit_c;
            bnd_reg      <= bnd_c;
            last_reg     <= last_c;
            job_slot_reg <= win_slot_reg;
            ws_reg       <= WIN_AW'(ws_sum);
            ds_reg       <= DLY_AW'(ds_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == awst_pkg::F_PLAN) begin
            dly_q_reg <= dly_mem[dly_slot_reg];
        end
        if (state_reg == awst_pkg::F_COMMIT && !drain_reg) begin
            dly_mem[ds_reg] <= {vel_reg, next_reg};
        end
    end

endmodule

// ===== sv/awst_back.sv =====
// back part: pressure window memory, stencil accumulation, velocity scaling, saturation
// depends on awst_pkg

module awst_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  awst_pkg::cfg_t     cfg,
    input  logic               q_empty,
    input  awst_pkg::job_t     q_job,
    output logic               q_pop,
    input  awst_pkg::win_wr_t  win_wr,
    output logic               clear_done,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_pressure,
    output logic               m_bnd,
    output logic               m_last
);

    localparam int WIN_AW = awst_pkg::WIN_AW;
    localparam int R_W    = awst_pkg::R_W;
    localparam int RING_W = awst_pkg::RING_W;
    localparam int ACC_W  = 40;
    localparam int TERM_W = 35;
    localparam int HALF_W = ACC_W / 2;
    localparam int PLO_W  = HALF_W + awst_pkg::VEL_W;
    localparam int PHI_W  = HALF_W + awst_pkg::VEL_W + 1;
    localparam int TOT_W  = PHI_W + HALF_W + 1;
    localparam int SCL_W  = TOT_W - 16;
    localparam int BASE_W = 34;
    localparam int SUM_W  = SCL_W + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

    awst_pkg::back_state_t state_reg, state_next;

    logic [31:0]              win_mem [awst_pkg::WIN_DEPTH];
    logic [WIN_AW-1:0]        clr_addr_reg;
    awst_pkg::job_t           job_reg;
    logic                     first_reg;
    logic [R_W-1:0]           r_reg;
    logic [2:0]               j_reg;
    logic [WIN_AW-1:0]        offx_reg;
    logic [WIN_AW-1:0]        offy_reg;
    logic [WIN_AW-1:0]        offz_reg;
    logic                     v1_reg;
    logic                     c1_reg;
    logic [31:0]              coef1_reg;
    logic [31:0]              rd_data_reg;
    logic                     v2_reg;
    logic                     c2_reg;
    logic signed [63:0]       prod_reg;
    logic [31:0]              pc_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [PLO_W-1:0]         plo_reg;
    logic signed [PHI_W-1:0]  phi_reg;
    logic signed [SCL_W-1:0]  scaled_reg;
    logic signed [BASE_W-1:0] base_reg;
    logic [31:0]              res_reg;

    logic                     rd_en;
    logic                     tap_last;
    logic [WIN_AW-1:0]        tap_off;
    logic [WIN_AW:0]          fwd_sum;
    logic [WIN_AW:0]          bwd_sum;
    logic [WIN_AW-1:0]        rd_addr;
    logic [31:0]              tap_coef;
    logic [R_W-1:0]           r_m1;
    logic signed [TERM_W-1:0] term;
    logic signed [ACC_W-1:0]  term_w;
    logic signed [TOT_W-1:0]  tot;
    logic signed [SUM_W-1:0]  sum_c;
    logic                     mem_we;
    logic [WIN_AW-1:0]        mem_waddr;
    logic [31:0]              mem_wdata;

    assign clear_done = (state_reg != awst_pkg::B_CLEAR);
    assign m_valid    = (state_reg == awst_pkg::B_OUT);
    assign m_pressure = res_reg;
    assign m_bnd      = job_reg.bnd;
    assign m_last     = job_reg.last;

    always_comb begin
        tap_last = !first_reg && j_reg == 3'd5 && r_reg == R_W'(awst_pkg::RADIUS);
        r_m1     = r_reg - 1'b1;
        unique case (j_reg[2:1])
            2'd0:    tap_off = offx_reg;
            2'd1:    tap_off = offy_reg;
            default: tap_off = offz_reg;
        endcase
        fwd_sum = {1'b0, job_reg.slot} + {1'b0, tap_off};
        if (fwd_sum >= (WIN_AW + 1)'(awst_pkg::WIN_DEPTH)) begin
            fwd_sum = fwd_sum - (WIN_AW + 1)'(awst_pkg::WIN_DEPTH);
        end
        bwd_sum = {1'b0, job_reg.slot} + (WIN_AW + 1)'(awst_pkg::WIN_DEPTH) - {1'b0, tap_off};
        if (bwd_sum >= (WIN_AW + 1)'(awst_pkg::WIN_DEPTH)) begin
            bwd_sum = bwd_sum - (WIN_AW + 1)'(awst_pkg::WIN_DEPTH);
        end
        if (first_reg) begin
            rd_addr  = job_reg.slot;
            tap_coef = cfg.coeff_center;
        end else begin
            rd_addr  = j_reg[0] ? WIN_AW'(bwd_sum) : WIN_AW'(fwd_sum);
            tap_coef = cfg.coeff_ring[RING_W'(r_m1)];
        end

        term   = prod_reg[63:29];
        term_w = c2_reg ? ACC_W'(term) + (ACC_W'(term) <<< 1) : ACC_W'(term);

        tot   = $signed({phi_reg[PHI_W-1], phi_reg, {HALF_W{1'b0}}})
              + $signed({{(TOT_W - PLO_W){1'b0}}, plo_reg});
        sum_c = {scaled_reg[SCL_W-1], scaled_reg}
              + {{(SUM_W - BASE_W){base_reg[BASE_W-1]}}, base_reg};

        mem_we    = (state_reg == awst_pkg::B_CLEAR) || win_wr.en;
        mem_waddr = (state_reg == awst_pkg::B_CLEAR) ? clr_addr_reg : win_wr.addr;
        mem_wdata = (state_reg == awst_pkg::B_CLEAR) ? '0 : win_wr.data;
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        unique case (state_reg)
            awst_pkg::B_CLEAR: begin
                if (clr_addr_reg == WIN_AW'(awst_pkg::WIN_DEPTH - 1)) begin
                    state_next = awst_pkg::B_IDLE;
                end
            end
            awst_pkg::B_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = q_job.bnd ? awst_pkg::B_OUT : awst_pkg::B_TAP;
                end
            end
            awst_pkg::B_TAP: begin
                rd_en = 1'b1;
                if (tap_last) begin
                    state_next = awst_pkg::B_FLUSH;
                end
            end
            awst_pkg::B_FLUSH: begin
                if (!v1_reg && !v2_reg) begin
                    state_next = awst_pkg::B_MLO;
                end
            end
            awst_pkg::B_MLO: state_next = awst_pkg::B_MHI;
            awst_pkg::B_MHI: state_next = awst_pkg::B_SUM;
            awst_pkg::B_SUM: state_next = awst_pkg::B_SAT;
            awst_pkg::B_SAT: state_next = awst_pkg::B_OUT;
            awst_pkg::B_OUT: begin
                if (m_ready) begin
                    state_next = awst_pkg::B_IDLE;
                end
            end
            default: state_next = awst_pkg::B_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= awst_pkg::B_CLEAR;
            clr_addr_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= rd_en;
            v2_reg    <= v1_reg;
            if (state_reg == awst_pkg::B_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg   <= q_job;
            res_reg   <= q_job.nxt;
            first_reg <= 1'b1;
            acc_reg   <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + term_w;
        end
        if (rd_en) begin
            c1_reg    <= first_reg;
            coef1_reg <= tap_coef;
            if (first_reg) begin
                first_reg <= 1'b0;
                r_reg     <= R_W'(1);
                j_reg     <= '0;
                offx_reg  <= WIN_AW'(1);
                offy_reg  <= WIN_AW'(job_reg.nx);
                offz_reg  <= WIN_AW'(job_reg.nxny);
            end else if (j_reg == 3'd5) begin
                j_reg    <= '0;
                r_reg    <= r_reg + 1'b1;
                offx_reg <= offx_reg + 1'b1;
                offy_reg <= offy_reg + WIN_AW'(job_reg.nx);
                offz_reg <= offz_reg + WIN_AW'(job_reg.nxny);
            end else begin
                j_reg <= j_reg + 1'b1;
            end
        end
        if (v1_reg) begin
            prod_reg <= $signed(rd_data_reg) * $signed(coef1_reg);
            c2_reg   <= c1_reg;
            if (c1_reg) begin
                pc_reg <= rd_data_reg;
            end
        end
        if (state_reg == awst_pkg::B_MLO) begin
            plo_reg <= PLO_W'(acc_reg[HALF_W-1:0]) * PLO_W'(job_reg.vel);
        end
        if (state_reg == awst_pkg::B_MHI) begin
            phi_reg <= $signed(acc_reg[ACC_W-1:HALF_W]) * $signed({1'b0, job_reg.vel});
        end
        if (state_reg == awst_pkg::B_SUM) begin
            scaled_reg <= tot[TOT_W-1:16];
            base_reg   <= $signed({pc_reg[31], pc_reg, 1'b0})
                        - $signed({{2{job_reg.nxt[31]}}, job_reg.nxt});
        end
        if (state_reg == awst_pkg::B_SAT) begin
            if (sum_c > SAT_HI) begin
                res_reg <= 32'h7fff_ffff;
            end else if (sum_c < SAT_LO) begin
                res_reg <= 32'h8000_0000;
            end else begin
                res_reg <= sum_c[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= win_mem[rd_addr];
        end
        if (mem_we) begin
            win_mem[mem_waddr] <= mem_wdata;
        end
    end

endmodule

// ===== sv/acoustic_wave_stencil_3d.sv =====
// top level: register file on the apb port, front, job queue and back of the stencil
// depends on awst_pkg, awst_front, awst_queue, awst_back
// an item steps through the front states F_IDLE, F_SIZE, F_PLAN and F_COMMIT; the front
// can run ahead of the back by up to the 4 jobs in the job queue; a boundary job goes
// from B_IDLE straight to B_OUT, an interior one first makes 25 window reads through one
// memory read port in B_TAP, then B_FLUSH, two multiply steps (B_MLO, B_MHI) and two add
// steps (B_SUM, B_SAT); each part takes one job at a time. Reset is synchronous; then
// the window memory is cleared one entry a cycle, s_tready low, apb writes taken as usual

module acoustic_wave_stencil_3d (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // prev_sample[31:0], old_next[63:32], velocity[87:64]
    input  logic [0:0]  s_tuser,   // drain
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // new_pressure
    output logic [0:0]  m_tuser,   // copied_boundary
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    awst_pkg::cfg_t    cfg_reg;
    awst_pkg::job_t    push_job;
    awst_pkg::job_t    head_job;
    awst_pkg::win_wr_t win_wr;
    awst_pkg::cfg_idx_t reg_idx;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    logic              clear_done;
    logic              cfg_we;

    assign pready  = 1'b1;
    assign reg_idx = awst_pkg::cfg_idx_t'(paddr[4:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coeff_center  <= -32'sd611436;
            cfg_reg.coeff_ring[0] <= 32'sd343597;
            cfg_reg.coeff_ring[1] <= -32'sd42950;
            cfg_reg.coeff_ring[2] <= 32'sd5454;
            cfg_reg.coeff_ring[3] <= -32'sd383;
            cfg_reg.grid_x        <= 9'd256;
            cfg_reg.grid_y        <= 9'd256;
            cfg_reg.grid_z        <= 11'd256;
        end else if (cfg_we) begin
            unique case (reg_idx)
                awst_pkg::CFG_COEFF_CENTER: cfg_reg.coeff_center  <= pwdata;
                awst_pkg::CFG_COEFF_1:      cfg_reg.coeff_ring[0] <= pwdata;
                awst_pkg::CFG_COEFF_2:      cfg_reg.coeff_ring[1] <= pwdata;
                awst_pkg::CFG_COEFF_3:      cfg_reg.coeff_ring[2] <= pwdata;
                awst_pkg::CFG_COEFF_4:      cfg_reg.coeff_ring[3] <= pwdata;
                awst_pkg::CFG_GRID_X:       cfg_reg.grid_x <= pwdata[awst_pkg::XS_W-1:0];
                awst_pkg::CFG_GRID_Y:       cfg_reg.grid_y <= pwdata[awst_pkg::YS_W-1:0];
                awst_pkg::CFG_GRID_Z:       cfg_reg.grid_z <= pwdata[awst_pkg::ZS_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            awst_pkg::CFG_COEFF_CENTER: prdata = cfg_reg.coeff_center;
            awst_pkg::CFG_COEFF_1:      prdata = cfg_reg.coeff_ring[0];
            awst_pkg::CFG_COEFF_2:      prdata = cfg_reg.coeff_ring[1];
            awst_pkg::CFG_COEFF_3:      prdata = cfg_reg.coeff_ring[2];
            awst_pkg::CFG_COEFF_4:      prdata = cfg_reg.coeff_ring[3];
            awst_pkg::CFG_GRID_X:       prdata = 32'(cfg_reg.grid_x);
            awst_pkg::CFG_GRID_Y:       prdata = 32'(cfg_reg.grid_y);
            awst_pkg::CFG_GRID_Z:       prdata = 32'(cfg_reg.grid_z);
        endcase
    end

    awst_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .in_prev    (s_tdata[31:0]),
        .in_next    (s_tdata[63:32]),
        .in_vel     (s_tdata[87:64]),
        .in_drain   (s_tuser[0]),
        .clear_done (clear_done),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job),
        .win_wr     (win_wr)
    );

    awst_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (push_job),
        .pop     (q_pop),
        .dout    (head_job),
        .full    (q_full),
        .empty   (q_empty)
    );

    awst_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_job      (head_job),
        .q_pop      (q_pop),
        .win_wr     (win_wr),
        .clear_done (clear_done),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_pressure (m_tdata),
        .m_bnd      (m_tuser[0]),
        .m_last     (m_tlast)
    );

endmodule

// ===== sv/awst_checker.sv =====
// port-level checks for the acoustic wave stencil, bound to the top level
// depends on acoustic_wave_stencil_3d

module awst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // last point of the volume lies on a face
    a_last_bnd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("final point not flagged as boundary");

    // window clearing keeps the input closed right after reset
    a_reset_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input open right after reset");

    // the front works on one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in consecutive cycles");

endmodule

bind acoustic_wave_stencil_3d awst_checker u_awst_checker (.*);
